// ----- rtl/core/dequ_pkg.sv -----
`timescale 1ns / 1ps

package dequ_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_GET        = 3'd4,
        OP_PEEK_FRONT = 3'd5,
        OP_PEEK_BACK  = 3'd6
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OOB   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;    // push front: take the word of the cell below
        logic shift_down;  // pop front: take the word of the cell above
        logic wr_tail;     // push back: the addressed cell loads the new word
    } t_cell_ctl;

endpackage

// ----- rtl/core/dequ_cell.sv -----
`timescale 1ns / 1ps

module dequ_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 6,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  dequ_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_below,
    input  logic [DATA_WIDTH-1:0] i_above,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic [IW-1:0]         i_wr_idx,
    input  logic [IW-1:0]         i_rd_idx,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic [DATA_WIDTH-1:0] o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_up) begin
            n_word = i_below;
        end else if (i_ctl.shift_down) begin
            n_word = i_above;
        end else if (i_ctl.wr_tail && (i_wr_idx == MY_IDX)) begin
            n_word = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // drive the read bus only when addressed
    assign o_rd   = r_word & {DATA_WIDTH{i_rd_idx == MY_IDX}};

endmodule

// ----- rtl/core/double_ended_queue.sv -----
`timescale 1ns / 1ps
// The result of each input transfer is registered and valid at the output in the next cycle.
// One operation per cycle unless o_stall holds the input; the chain of cells shifts or loads in the
// same cycle the item is taken, and the result register frees as it drains.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// stored words are not cleared.

module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_operation,
    input  logic [DATA_WIDTH-1:0]      i_data_in,
    input  logic [$clog2(DEPTH)-1:0]   i_offset,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [DATA_WIDTH-1:0]      o_data_out,
    output logic [1:0]                 o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [1:0]            r_status;
    logic [CW-1:0]         r_out_count;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  rd_ok;
    logic [1:0]            n_status;
    logic [IW-1:0]         rd_idx;
    logic [IW-1:0]         tail_idx;
    logic [IW-1:0]         last_idx;
    logic [DATA_WIDTH-1:0] rd_word;
    dequ_pkg::t_cell_ctl   cmd;
    dequ_pkg::t_cell_ctl   cell_ctl;

    logic [DATA_WIDTH-1:0] cell_word [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];

    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign tail_idx = r_count[IW-1:0];
    assign last_idx = tail_idx - IW'(1);

    always_comb begin
        cmd      = '0;
        n_count  = r_count;
        n_status = dequ_pkg::ST_OK;
        rd_ok    = 1'b0;
        rd_idx   = '0;
        case (dequ_pkg::t_op'(i_operation))
            dequ_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = dequ_pkg::ST_FULL;
                end else begin
                    cmd.shift_up = 1'b1;
                    n_count      = r_count + ONE_CNT;
                end
            end
            dequ_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    n_status = dequ_pkg::ST_FULL;
                end else begin
                    cmd.wr_tail = 1'b1;
                    n_count     = r_count + ONE_CNT;
                end
            end
            dequ_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_status = dequ_pkg::ST_EMPTY;
                end else begin
                    rd_ok          = 1'b1;
                    cmd.shift_down = 1'b1;
                    n_count        = r_count - ONE_CNT;
                end
            end
            dequ_pkg::OP_POP_BACK: begin
                if (empty) begin
                    n_status = dequ_pkg::ST_EMPTY;
                end else begin
                    rd_ok   = 1'b1;
                    rd_idx  = last_idx;
                    n_count = r_count - ONE_CNT;
                end
            end
            dequ_pkg::OP_GET: begin
                if (CW'(i_offset) >= r_count) begin
                    n_status = dequ_pkg::ST_OOB;
                end else begin
                    rd_ok  = 1'b1;
                    rd_idx = i_offset;
                end
            end
            dequ_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = dequ_pkg::ST_EMPTY;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            dequ_pkg::OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = dequ_pkg::ST_EMPTY;
                end else begin
                    rd_ok  = 1'b1;
                    rd_idx = last_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // hold the chain unless an item transfers this cycle
    assign cell_ctl = accept ? cmd : '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dequ_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_below  ((g == 0) ? i_data_in : cell_word[(g == 0) ? 0 : g - 1]),
            .i_above  (cell_word[(g == DEPTH - 1) ? g : g + 1]),
            .i_data   (i_data_in),
            .i_wr_idx (tail_idx),
            .i_rd_idx (rd_idx),
            .o_word   (cell_word[g]),
            .o_rd     (cell_rd[g])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_word = rd_word | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data      <= rd_ok ? rd_word : '0;
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_data;
    assign o_status   = r_status;
    assign o_count    = r_out_count;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH      = 64;
    localparam int DW         = 32;
    localparam int LIMIT      = 300000;
    localparam int N_RANDOM   = 1750;

    typedef struct {
        dequ_pkg::t_op op;
        logic [DW-1:0] word;
        logic [5:0]    off;
        bit            sync;   // hold until every outstanding result is back
    } t_deq_cmd;

    typedef struct {
        logic [DW-1:0] data;
        logic [1:0]    status;
        logic [6:0]    count;
    } t_deq_res;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_stall;
    logic [2:0]    i_operation = '0;
    logic [DW-1:0] i_data_in   = '0;
    logic [5:0]    i_offset    = '0;
    logic          o_valid;
    logic          i_stall     = 1'b0;
    logic [DW-1:0] o_data_out;
    logic [1:0]    o_status;
    logic [6:0]    o_count;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_data_in   (i_data_in),
        .i_offset    (i_offset),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow deque state
    logic [DW-1:0] ring_mem [DEPTH];
    logic [5:0]    head_ptr = '0;
    logic [6:0]    fill_cnt = '0;

    t_deq_cmd cmd_q [$];
    t_deq_res pred_q [$];
    t_deq_cmd cur_cmd;

    int n_total    = 0;
    int n_taken    = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int cycle_cnt  = 0;
    int gap_left   = 0;
    int hold_left  = 0;
    bit tx_burst   = 1'b0;
    bit rx_burst   = 1'b0;
    int op_hits [7];
    int st_hits [4];
    int peak_fill  = 0;

    function automatic t_deq_res deque_step(t_deq_cmd c);
        t_deq_res r;
        logic [5:0] tail;
        r.data   = '0;
        r.status = dequ_pkg::ST_OK;
        tail     = head_ptr + 6'(fill_cnt) - 6'd1;
        case (c.op)
            dequ_pkg::OP_PUSH_FRONT: begin
                if (fill_cnt >= DEPTH) begin
                    r.status = dequ_pkg::ST_FULL;
                end else begin
                    head_ptr = head_ptr - 6'd1;
                    ring_mem[head_ptr] = c.word;
                    fill_cnt = fill_cnt + 7'd1;
                end
            end
            dequ_pkg::OP_PUSH_BACK: begin
                if (fill_cnt >= DEPTH) begin
                    r.status = dequ_pkg::ST_FULL;
                end else begin
                    ring_mem[head_ptr + 6'(fill_cnt)] = c.word;
                    fill_cnt = fill_cnt + 7'd1;
                end
            end
            dequ_pkg::OP_POP_FRONT: begin
                if (fill_cnt == 0) begin
                    r.status = dequ_pkg::ST_EMPTY;
                end else begin
                    r.data   = ring_mem[head_ptr];
                    head_ptr = head_ptr + 6'd1;
                    fill_cnt = fill_cnt - 7'd1;
                end
            end
            dequ_pkg::OP_POP_BACK: begin
                if (fill_cnt == 0) begin
                    r.status = dequ_pkg::ST_EMPTY;
                end else begin
                    r.data   = ring_mem[tail];
                    fill_cnt = fill_cnt - 7'd1;
                end
            end
            dequ_pkg::OP_GET: begin
                if (7'(c.off) >= fill_cnt) begin
                    r.status = dequ_pkg::ST_OOB;
                end else begin
                    r.data = ring_mem[head_ptr + c.off];
                end
            end
            dequ_pkg::OP_PEEK_FRONT: begin
                if (fill_cnt == 0) r.status = dequ_pkg::ST_EMPTY;
                else r.data = ring_mem[head_ptr];
            end
            dequ_pkg::OP_PEEK_BACK: begin
                if (fill_cnt == 0) r.status = dequ_pkg::ST_EMPTY;
                else r.data = ring_mem[tail];
            end
            default: ;
        endcase
        r.count = fill_cnt;
        op_hits[c.op] = op_hits[c.op] + 1;
        st_hits[r.status] = st_hits[r.status] + 1;
        if (int'(fill_cnt) > peak_fill) peak_fill = int'(fill_cnt);
        return r;
    endfunction

    // Driver: one transfer per accepted command, random gaps between commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pred_q.push_back(deque_step(cur_cmd));
                n_taken   = n_taken + 1;
                gap_left  = tx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() > 0 && !(cmd_q[0].sync && pred_q.size() > 0)) begin
                    cur_cmd = cmd_q.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= cur_cmd.op;
                    i_data_in   <= cur_cmd.word;
                    i_offset    <= cur_cmd.off;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_deq_res w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pred_q.size() == 0) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected result data=%h status=%0d count=%0d",
                                 o_data_out, o_status, o_count);
                end else begin
                    w = pred_q.pop_front();
                    n_checked = n_checked + 1;
                    if (o_data_out !== w.data || o_status !== w.status
                            || o_count !== w.count) begin
                        n_errors = n_errors + 1;
                        if (n_errors <= 10) begin
                            $write("ERROR: result %0d: expected data=%h status=%0d count=%0d,",
                                   n_checked, w.data, w.status, w.count);
                            $display(" got data=%h status=%0d count=%0d",
                                     o_data_out, o_status, o_count);
                        end
                    end
                end
                hold_left = rx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            end else if (hold_left > 0) begin
                hold_left = hold_left - 1;
            end
            i_stall <= (hold_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pred_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Segment styles: 0 mixed, 1 fill toward full, 2 drain toward empty, 3 indexed reads
    function automatic t_deq_cmd rand_cmd(int style);
        t_deq_cmd c;
        int       r;
        r      = $urandom_range(0, 9);
        c.op   = dequ_pkg::t_op'($urandom_range(0, 6));
        c.word = rand_word();
        c.off  = 6'($urandom_range(0, 63));
        c.sync = 1'b0;
        case (style)
            1: if (r < 8) c.op = r[0] ? dequ_pkg::OP_PUSH_BACK : dequ_pkg::OP_PUSH_FRONT;
            2: if (r < 8) c.op = dequ_pkg::t_op'($urandom_range(2, 3));
            3: begin
                if (r < 6) c.op = dequ_pkg::OP_GET;
                if (r < 3) c.off = 6'($urandom_range(0, 15));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic add_cmd(dequ_pkg::t_op op, logic [DW-1:0] word, logic [5:0] off);
        t_deq_cmd c;
        c.op   = op;
        c.word = word;
        c.off  = off;
        c.sync = 1'b0;
        cmd_q.push_back(c);
    endtask

    initial begin
        int       style;
        int       seg_len;
        int       n_rand;
        t_deq_cmd c;

        // Directed: empty queue errors, both ends, indexed reads, bounds
        add_cmd(dequ_pkg::OP_PEEK_FRONT, '0, '0);
        add_cmd(dequ_pkg::OP_PEEK_BACK,  '0, '0);
        add_cmd(dequ_pkg::OP_POP_FRONT,  '0, '0);
        add_cmd(dequ_pkg::OP_POP_BACK,   '0, '0);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd0);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd63);
        add_cmd(dequ_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, 6'd63);
        add_cmd(dequ_pkg::OP_PUSH_FRONT, 32'h0000_0000, 6'd0);
        add_cmd(dequ_pkg::OP_PUSH_BACK,  32'hA5A5_A5A5, 6'd0);
        add_cmd(dequ_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 6'd0);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd0);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd1);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd2);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd3);
        add_cmd(dequ_pkg::OP_GET,        '0, 6'd4);
        add_cmd(dequ_pkg::OP_GET,        '1, 6'd63);
        add_cmd(dequ_pkg::OP_PEEK_FRONT, '0, '0);
        add_cmd(dequ_pkg::OP_PEEK_BACK,  '0, '0);
        add_cmd(dequ_pkg::OP_POP_BACK,   '0, '0);
        add_cmd(dequ_pkg::OP_POP_FRONT,  '0, '0);
        add_cmd(dequ_pkg::OP_POP_FRONT,  '0, '0);
        add_cmd(dequ_pkg::OP_POP_BACK,   '0, '0);
        add_cmd(dequ_pkg::OP_POP_FRONT,  '0, '0);

        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            style   = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 100);
            repeat (seg_len) begin
                c = rand_cmd(style);
                if (n_rand % 400 == 0) c.sync = 1'b1;
                cmd_q.push_back(c);
                n_rand = n_rand + 1;
            end
        end
        n_total = cmd_q.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total) @(posedge i_clk);
        while (pred_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: push %0d/%0d, pop %0d/%0d, get %0d, peek %0d/%0d",
                 n_checked, op_hits[dequ_pkg::OP_PUSH_FRONT],
                 op_hits[dequ_pkg::OP_PUSH_BACK],
                 op_hits[dequ_pkg::OP_POP_FRONT], op_hits[dequ_pkg::OP_POP_BACK],
                 op_hits[dequ_pkg::OP_GET],
                 op_hits[dequ_pkg::OP_PEEK_FRONT], op_hits[dequ_pkg::OP_PEEK_BACK]);
        $display("Status ok %0d, empty %0d, out of range %0d, full %0d; peak fill %0d",
                 st_hits[dequ_pkg::ST_OK], st_hits[dequ_pkg::ST_EMPTY],
                 st_hits[dequ_pkg::ST_OOB], st_hits[dequ_pkg::ST_FULL],
                 peak_fill);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
